@@ hdl/fcsg_pkg.sv @@
// fcsg_pkg: shared types and codes for the filled-circle span generator.
// No dependencies; imported by the front, queue, back and top-level modules.
package fcsg_pkg;

	// s_tuser[0] selects the kind of input item
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 64;

	// one step of the walk, as handed from front to back
	typedef struct packed {
		logic       done;
		logic [7:0] cx;
		logic [7:0] cy;
		logic [7:0] xo;   // unsigned
		logic [7:0] yo;   // two's complement
	} cmd_t;

	localparam int unsigned CMD_W = $bits(cmd_t);

	// order of the four spans per point
	typedef enum logic [1:0] {
		SEL_ROW_PY = 2'd0,  // cx-x..cx+x on cy+y
		SEL_ROW_NY = 2'd1,  // cx-x..cx+x on cy-y
		SEL_ROW_PX = 2'd2,  // cx-y..cx+y on cy+x
		SEL_ROW_NX = 2'd3   // cx-y..cx+y on cy-x
	} span_sel_t;

endpackage

@@ hdl/fcsg_front.sv @@
// fcsg_front: accepts input items, runs the midpoint walk state, emits one command per item.
// Depends on fcsg_pkg (cmd_t, action codes).
module fcsg_front
	import fcsg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       action,
	input  logic [7:0] center_x,
	input  logic [7:0] center_y,
	input  logic [6:0] radius,
	output cmd_t       cmd
);

	logic [7:0]  center_col_q, center_row_q, x_offset_q, y_offset_q;
	logic [15:0] decision_q;

	logic [8:0]  x9, y9, xn9, yn9;
	logic [15:0] xn16, yn16, d_next;
	logic        finished, d_pos;

	always_comb begin
		x9       = {1'b0, x_offset_q};
		y9       = {y_offset_q[7], y_offset_q};
		finished = $signed(y9) < $signed(x9);
		d_pos    = $signed(decision_q) > 16'sd0;
		xn9      = x9 + 9'd1;
		yn9      = d_pos ? (y9 - 9'd1) : y9;
		xn16     = {7'b0, xn9};
		yn16     = {{7{yn9[8]}}, yn9};
		if (d_pos) begin
			d_next = decision_q + ((xn16 - yn16) << 2) + 16'd10;
		end else begin
			d_next = decision_q + (xn16 << 2) + 16'd6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= '0;
			center_row_q <= '0;
			x_offset_q   <= '0;
			y_offset_q   <= '0;
			decision_q   <= '0;
		end else if (accept) begin
			if (action == ACT_START) begin
				center_col_q <= center_x;
				center_row_q <= center_y;
				x_offset_q   <= '0;
				y_offset_q   <= {1'b0, radius};
				decision_q   <= 16'd3 - {8'b0, radius, 1'b0};
			end else if (!finished) begin
				x_offset_q <= xn9[7:0];
				y_offset_q <= yn9[7:0];
				decision_q <= d_next;
			end
		end
	end

	// command reflects the state after this item
	always_comb begin
		cmd.done = 1'b0;
		cmd.cx   = center_col_q;
		cmd.cy   = center_row_q;
		cmd.xo   = xn9[7:0];
		cmd.yo   = yn9[7:0];
		if (action == ACT_START) begin
			cmd.cx = center_x;
			cmd.cy = center_y;
			cmd.xo = '0;
			cmd.yo = {1'b0, radius};
		end else if (finished) begin
			cmd.done = 1'b1;
		end
	end

endmodule

@@ hdl/fcsg_queue.sv @@
// fcsg_queue: small register FIFO of commands between front and back.
// Depends on fcsg_pkg (cmd_t).
module fcsg_queue
	import fcsg_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output cmd_t head
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ hdl/fcsg_back.sv @@
// fcsg_back: expands each command into four spans (or one done item) into the output register.
// Depends on fcsg_pkg (cmd_t, span_sel_t); holds the fill color register.
module fcsg_back
	import fcsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_data,
	output logic        out_last,
	output logic        out_done
);

	logic [15:0] fill_color_q;
	span_sel_t   sel_q;
	logic        load;
	logic [15:0] cx16, cy16, xh, yh, half, row;
	logic [15:0] st_q, en_q, row_q, col_q;

	assign load    = cmd_valid && (!out_valid || out_ready);
	assign cmd_pop = load && (cmd.done || sel_q == SEL_ROW_NX);

	always_comb begin
		cx16 = {8'b0, cmd.cx};
		cy16 = {8'b0, cmd.cy};
		xh   = {8'b0, cmd.xo};
		yh   = {{8{cmd.yo[7]}}, cmd.yo};
		unique case (sel_q)
			SEL_ROW_PY: begin half = xh; row = cy16 + yh; end
			SEL_ROW_NY: begin half = xh; row = cy16 - yh; end
			SEL_ROW_PX: begin half = yh; row = cy16 + xh; end
			SEL_ROW_NX: begin half = yh; row = cy16 - xh; end
			default:    begin half = xh; row = cy16 + yh; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_color_q <= '0;
			sel_q        <= SEL_ROW_PY;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fill_color_q <= cfg_wr_data;
			end
			if (load) begin
				out_valid <= 1'b1;
				if (cmd.done || sel_q == SEL_ROW_NX) begin
					sel_q <= SEL_ROW_PY;
				end else begin
					sel_q <= span_sel_t'(sel_q + 2'd1);
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (cmd.done) begin
				st_q     <= '0;
				en_q     <= '0;
				row_q    <= '0;
				col_q    <= '0;
				out_last <= 1'b1;
				out_done <= 1'b1;
			end else begin
				st_q     <= cx16 - half;
				en_q     <= cx16 + half;
				row_q    <= row;
				col_q    <= fill_color_q;
				out_last <= (sel_q == SEL_ROW_NX);
				out_done <= 1'b0;
			end
		end
	end

	assign out_data = {col_q, row_q, en_q, st_q};

endmodule

@@ hdl/filled_circle_span_generator.sv @@
// filled_circle_span_generator: top level of the midpoint filled-circle span rasterizer.
// Depends on fcsg_pkg, fcsg_front, fcsg_queue and fcsg_back.
//
// Usage
//   Input stream (s_*): one item per command. s_tuser selects start or advance.
//   A start item loads center and radius; each advance item runs one midpoint step.
//   Output stream (m_*): one horizontal span per item, four per step; m_tlast marks
//   the fourth. Once the walk is over, an advance gives one item with m_tuser set
//   (done) and m_tlast set, all span fields zero.
//   cfg_wr_en / cfg_wr_data write the fill color; write it only while idle.
// Timing
//   The first span is presented once the command has passed through the queue: the command
//   enters the queue on the accepting edge and is then loaded into the output register.
//   While commands are queued and m_tready is high, the back end emits one span per cycle,
//   so a step item takes four spans of output bandwidth and a done item takes one; sustained
//   throughput is set by the single output channel.
// Stalls and reset
//   m_tready low holds the output register; the command queue (QUEUE_DEPTH entries)
//   keeps absorbing input items until full, then s_tready drops.
//   arst_n clears walk state, fill color, the queue and the output valid.
module filled_circle_span_generator
	import fcsg_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,   // fill_color
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,       // center_x[7:0], center_y[15:8], radius[22:16]
	input  logic [0:0]            s_tuser,       // action
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,       // span_start, span_end, span_row, span_color
	output logic                  m_tlast,       // last
	output logic [0:0]            m_tuser        // done_res
);

	logic accept;
	logic q_full, q_nonempty, q_pop;
	cmd_t cmd_in, cmd_head;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// front: walk state and classification
	fcsg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.action   (s_tuser[0]),
		.center_x (s_tdata[7:0]),
		.center_y (s_tdata[15:8]),
		.radius   (s_tdata[22:16]),
		.cmd      (cmd_in)
	);

	// decoupling queue
	fcsg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wdata    (cmd_in),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (cmd_head)
	);

	// back: span expansion and output register
	fcsg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (q_nonempty),
		.cmd         (cmd_head),
		.cmd_pop     (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_last    (m_tlast),
		.out_done    (m_tuser[0])
	);

endmodule
